// File: sv/cos_pkg.sv
// ----------------------------------------------------------------------------
// cos_pkg
// Shared types and constants for the cursor overlay save/restore block.
// ----------------------------------------------------------------------------
package cos_pkg;

	localparam int CURSOR_SIZE = 16;
	localparam int CELLS       = CURSOR_SIZE * CURSOR_SIZE;
	localparam int IDX_W       = $clog2(CELLS);

	localparam int ADDR_W  = 48;
	localparam int PIX_W   = 32;
	localparam int POS_W   = 12;
	localparam int OFF_W   = 4;
	localparam int DIM_W   = 13;
	localparam int PADDR_W = 5;
	localparam int PDATA_W = 64;

	// Register indexes, at byte address 8 * index.
	localparam logic [1:0] REG_FRAME_BASE    = 2'd0;
	localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd1;
	localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd2;
	localparam logic [1:0] REG_ROW_PITCH     = 2'd3;

	localparam logic [DIM_W-1:0] RST_SCREEN_WIDTH  = 13'd640;
	localparam logic [DIM_W-1:0] RST_SCREEN_HEIGHT = 13'd480;
	localparam logic [DIM_W-1:0] RST_ROW_PITCH     = 13'd640;

	// Item kinds.
	localparam logic KIND_DRAW  = 1'b0;
	localparam logic KIND_CLEAR = 1'b1;

	typedef struct packed {
		logic [ADDR_W-1:0] frame_base;
		logic [DIM_W-1:0]  screen_width;
		logic [DIM_W-1:0]  screen_height;
		logic [DIM_W-1:0]  row_pitch;
	} cfg_t;

	typedef struct packed {
		logic             kind;
		logic [POS_W-1:0] pos_x;
		logic [POS_W-1:0] pos_y;
		logic [OFF_W-1:0] offset_x;
		logic [OFF_W-1:0] offset_y;
		logic             shape_bit;
		logic [PIX_W-1:0] current_pixel;
		logic [PIX_W-1:0] draw_colour;
	} item_t;

	typedef struct packed {
		logic              write_enable;
		logic [ADDR_W-1:0] write_address;
		logic [PIX_W-1:0]  write_value;
		logic              clipped;
	} result_t;

	// One save-under entry: the pixel that was under the cursor and the
	// colour that was put over it.
	typedef struct packed {
		logic [PIX_W-1:0] saved_under;
		logic [PIX_W-1:0] drawn_value;
	} entry_t;

	typedef struct packed {
		logic             wr_en;
		logic [IDX_W-1:0] wr_idx;
		logic             rd_en;
		logic [IDX_W-1:0] rd_idx;
	} store_ctl_t;

endpackage

// File: sv/cos_cfg_regs.sv
// ----------------------------------------------------------------------------
// cos_cfg_regs
// APB register file holding frame base, screen size and row pitch.
// ----------------------------------------------------------------------------
module cos_cfg_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [cos_pkg::PADDR_W-1:0] paddr,
	input  logic [cos_pkg::PDATA_W-1:0] pwdata,
	output logic [cos_pkg::PDATA_W-1:0] prdata,
	output logic                        pready,
	output cos_pkg::cfg_t               cfg
);
	import cos_pkg::*;

	cfg_t       cfg_q;
	logic [1:0] reg_idx;
	logic       wr_hit;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:3];
	assign wr_hit  = psel && penable && pwrite && pready;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_base    <= '0;
			cfg_q.screen_width  <= RST_SCREEN_WIDTH;
			cfg_q.screen_height <= RST_SCREEN_HEIGHT;
			cfg_q.row_pitch     <= RST_ROW_PITCH;
		end else if (wr_hit) begin
			case (reg_idx)
				REG_FRAME_BASE:    cfg_q.frame_base    <= pwdata[ADDR_W-1:0];
				REG_SCREEN_WIDTH:  cfg_q.screen_width  <= pwdata[DIM_W-1:0];
				REG_SCREEN_HEIGHT: cfg_q.screen_height <= pwdata[DIM_W-1:0];
				REG_ROW_PITCH:     cfg_q.row_pitch     <= pwdata[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_FRAME_BASE:    prdata = PDATA_W'(cfg_q.frame_base);
			REG_SCREEN_WIDTH:  prdata = PDATA_W'(cfg_q.screen_width);
			REG_SCREEN_HEIGHT: prdata = PDATA_W'(cfg_q.screen_height);
			REG_ROW_PITCH:     prdata = PDATA_W'(cfg_q.row_pitch);
			default:           prdata = '0;
		endcase
	end

endmodule

// File: sv/cos_store.sv
// ----------------------------------------------------------------------------
// cos_store
// Save-under memory: one entry per cursor pixel, registered read.
// ----------------------------------------------------------------------------
module cos_store (
	input  logic                clk,
	input  cos_pkg::store_ctl_t ctl,
	input  cos_pkg::entry_t     wr_data,
	output cos_pkg::entry_t     rd_data
);
	import cos_pkg::*;

	entry_t mem [CELLS];
	entry_t rd_q;

	assign rd_data = rd_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[ctl.wr_idx] <= wr_data;
		end
	end

	// A write in the same cycle to the address being read is passed through,
	// so the next item sees the entry the item ahead of it just stored.
	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			if (ctl.wr_en && (ctl.wr_idx == ctl.rd_idx)) begin
				rd_q <= wr_data;
			end else begin
				rd_q <= mem[ctl.rd_idx];
			end
		end
	end

endmodule

// File: sv/cursor_overlay_save_restore.sv
// ----------------------------------------------------------------------------
// cursor_overlay_save_restore
// Software cursor overlay with save-under, one cursor pixel per transfer.
// ----------------------------------------------------------------------------
// Each transfer on the item channel names one pixel of the 16x16 cursor, the
// pixel currently in the framebuffer there and the colour to draw. Each item
// gives exactly one transfer on the result channel: a framebuffer write
// request (enable, byte address, value) and a clip flag.
// A draw item with its shape bit set on screen saves the pixel underneath and
// asks for the colour to be written; a clear item restores the saved pixel
// where the framebuffer still holds the drawn colour.
// An item taken is registered into the working stage, then into the result
// register. One item is taken per cycle unless the result stalls; the address
// path holds one 13x13 multiply and the 48-bit add, and the save-under memory
// has one write and one registered read port.
// When the receiver stalls, the result holds and, if the working stage is empty,
// one further item is taken into it before item_stall rises.
// Reset restores the register defaults (640x480, pitch 640, base 0) and clears
// the drawn flag; the save-under memory is not cleared, needing no clearing time.
// The user writes registers through the APB port while idle; nothing enforces it.
// ----------------------------------------------------------------------------
module cursor_overlay_save_restore (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [cos_pkg::PADDR_W-1:0] paddr,
	input  logic [cos_pkg::PDATA_W-1:0] pwdata,
	output logic [cos_pkg::PDATA_W-1:0] prdata,
	output logic                        pready,
	input  logic                        item_valid,
	output logic                        item_stall,
	input  cos_pkg::item_t              item,
	output logic                        result_valid,
	input  logic                        result_stall,
	output cos_pkg::result_t            result
);
	import cos_pkg::*;

	cfg_t       cfg;
	store_ctl_t store_ctl;
	entry_t     store_wr;
	entry_t     store_rd;

	// Input side.
	logic             accept;
	logic [DIM_W-1:0] px_in;
	logic [DIM_W-1:0] py_in;
	logic             clip_in;
	logic             in_cursor;
	logic [IDX_W-1:0] idx_in;

	// Working stage.
	logic             valid_s1;
	logic             kind_s1;
	logic             active_s1;
	logic             clip_s1;
	logic [DIM_W-1:0] px_s1;
	logic [DIM_W-1:0] py_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [PIX_W-1:0] cur_s1;
	logic [PIX_W-1:0] colour_s1;

	logic                   adv_s1;
	logic [2*DIM_W-1:0]     prod;
	logic [2*DIM_W:0]       lin;
	logic [ADDR_W-1:0]      addr;
	logic                   we;
	logic [PIX_W-1:0]       val;
	logic                   draw_s1;

	logic    cursor_drawn_q;
	logic    result_valid_q;
	result_t result_q;

	cos_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	cos_store u_store (
		.clk     (clk),
		.ctl     (store_ctl),
		.wr_data (store_wr),
		.rd_data (store_rd)
	);

	// Handshake.
	assign adv_s1     = valid_s1 && (!result_valid_q || !result_stall);
	assign item_stall = valid_s1 && !adv_s1;
	assign accept     = item_valid && !item_stall;

	// Screen position, clipping and cursor cell of the incoming item.
	always_comb begin
		px_in     = DIM_W'(item.pos_x) + DIM_W'(item.offset_x);
		py_in     = DIM_W'(item.pos_y) + DIM_W'(item.offset_y);
		clip_in   = (px_in >= cfg.screen_width) || (py_in >= cfg.screen_height);
		in_cursor = (int'(item.offset_x) < CURSOR_SIZE) &&
		            (int'(item.offset_y) < CURSOR_SIZE);
		if (in_cursor) begin
			idx_in = IDX_W'(int'(item.offset_y) * CURSOR_SIZE + int'(item.offset_x));
		end else begin
			idx_in = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1   <= item.kind;
			active_s1 <= item.shape_bit && in_cursor && !clip_in;
			clip_s1   <= clip_in;
			px_s1     <= px_in;
			py_s1     <= py_in;
			idx_s1    <= idx_in;
			cur_s1    <= item.current_pixel;
			colour_s1 <= item.draw_colour;
		end
	end

	// Result of the item in the working stage.
	always_comb begin
		draw_s1 = (kind_s1 == KIND_DRAW);
		prod    = (2*DIM_W)'(py_s1) * (2*DIM_W)'(cfg.row_pitch);
		lin     = (2*DIM_W+1)'(prod) + (2*DIM_W+1)'(px_s1);
		addr    = cfg.frame_base + ADDR_W'({lin, 2'b00});
		if (draw_s1) begin
			we  = active_s1;
			val = active_s1 ? colour_s1 : '0;
		end else begin
			we  = cursor_drawn_q && active_s1 && (cur_s1 == store_rd.drawn_value);
			val = we ? store_rd.saved_under : '0;
		end
	end

	assign store_ctl.wr_en  = adv_s1 && draw_s1 && active_s1;
	assign store_ctl.wr_idx = idx_s1;
	assign store_ctl.rd_en  = accept;
	assign store_ctl.rd_idx = idx_in;
	assign store_wr.saved_under = cur_s1;
	assign store_wr.drawn_value = colour_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_drawn_q <= 1'b0;
		end else if (adv_s1 && draw_s1) begin
			cursor_drawn_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (adv_s1) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			result_q.write_enable  <= we;
			result_q.write_address <= addr;
			result_q.write_value   <= val;
			result_q.clipped       <= clip_s1;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// File: sv/cos_checker.sv
// ----------------------------------------------------------------------------
// cos_port_checks
// Port-level checks for the cursor overlay block, bound to the top level.
// ----------------------------------------------------------------------------
module cos_port_checks (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       item_valid,
	input logic                       item_stall,
	input logic                       result_valid,
	input logic                       result_stall,
	input cos_pkg::result_t           result
);
	import cos_pkg::*;

	// A stalled result stays offered and unchanged.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed or dropped");

	// A clipped pixel is never written.
	a_no_clipped_write: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(result.write_enable && result.clipped))
		else $error("write requested for a clipped pixel");

	// No write means a zero value.
	a_idle_value: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.write_enable |-> result.write_value == '0)
		else $error("nonzero value without write enable");

	// A transfer in is followed by a result, through the working stage and
	// the result register, when the receiver is not stalling in between.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall) ##1 !result_stall |=> result_valid)
		else $error("result missing after accepted item");

endmodule

bind cursor_overlay_save_restore cos_port_checks u_cos_port_checks (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
